// File: rtl/per_process_page_table_mmu_top_defines.svh
// Assertion macros used by the page table MMU controller.
`ifndef PER_PROCESS_PAGE_TABLE_MMU_TOP_DEFINES_SVH
`define PER_PROCESS_PAGE_TABLE_MMU_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked property check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Clocked implication check, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, pre, post)
`endif
`endif

// File: rtl/ppmmu_pkg.sv
// Types and codes shared by the page table MMU modules.
`timescale 1ns / 1ps
package ppmmu_pkg;

   // Fixed virtual address width of the request transaction.
   localparam int VA_W = 6;

   // Operation codes.
   localparam logic [1:0] FUNC_MAP   = 2'd0;
   localparam logic [1:0] FUNC_STORE = 2'd1;
   localparam logic [1:0] FUNC_LOAD  = 2'd2;

   // Response status codes.
   localparam logic [2:0] STATUS_MAPPED    = 3'd0;
   localparam logic [2:0] STATUS_ALREADY   = 3'd1;
   localparam logic [2:0] STATUS_STORED    = 3'd2;
   localparam logic [2:0] STATUS_PROTECTED = 3'd3;
   localparam logic [2:0] STATUS_INVALID   = 3'd4;
   localparam logic [2:0] STATUS_LOADED    = 3'd5;

   typedef struct packed {
      logic [1:0]      func;
      logic [1:0]      process_id;
      logic [VA_W-1:0] virtual_address;
      logic [7:0]      value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] frame_number;
      logic [7:0] physical_address;
      logic [7:0] read_data;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic exec;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
   } dp_status_type;

endpackage

// File: rtl/per_process_page_table_mmu_top.sv
// An accepted request passes through the execute and finish steps, and the
// response register loads from the finish step once it is free. A new request
// is taken only when idle or in the finish step, so one request completes
// before the next starts; a stalled response holds the next one.
// Reset: synchronous, active high; valid bits clear at once, then a clearing pass
// writes zero to all NUM_PROCS*PAGES_PER_PROC*PAGE_BYTES bytes with req_ready low.
`timescale 1ns / 1ps
module per_process_page_table_mmu_top #(
   parameter int NUM_PROCS      = 4,
   parameter int PAGES_PER_PROC = 4,
   parameter int PAGE_BYTES     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ppmmu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ppmmu_pkg::rsp_type rsp_data
);

   ppmmu_pkg::ctrl_cmd_type  cmd;
   ppmmu_pkg::dp_status_type stat;

   // Sequencing of clear, accept, execute and response steps.
   ppmmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Page table, byte memory and response register.
   ppmmu_dp #(
      .NUM_PROCS      (NUM_PROCS),
      .PAGES_PER_PROC (PAGES_PER_PROC),
      .PAGE_BYTES     (PAGE_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/ppmmu_ctrl.sv
// Controller state machine of the page table MMU.
`timescale 1ns / 1ps
`include "per_process_page_table_mmu_top_defines.svh"
module ppmmu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ppmmu_pkg::dp_status_type stat,
   output ppmmu_pkg::ctrl_cmd_type  cmd
);

   ppmmu_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The output register can take a new response when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppmmu_pkg::ST_CLEAR: begin
            if (stat.clear_done) state_in = ppmmu_pkg::ST_IDLE;
         end
         ppmmu_pkg::ST_IDLE: begin
            if (req_valid) state_in = ppmmu_pkg::ST_EXEC;
         end
         ppmmu_pkg::ST_EXEC: begin
            state_in = ppmmu_pkg::ST_FINISH;
         end
         ppmmu_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = req_valid ? ppmmu_pkg::ST_EXEC : ppmmu_pkg::ST_IDLE;
            end
         end
         default: state_in = ppmmu_pkg::ST_CLEAR;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ppmmu_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ppmmu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ppmmu_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ppmmu_pkg::ST_FINISH: begin
            req_ready    = out_free;
            cmd.out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.accept = req_valid && req_ready;
   end

   // Response valid flag: set on load, cleared when the transaction is taken.
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppmmu_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted request always moves into execution on the next cycle.
   `ASSERT_CLK(a_accept_exec, clock, reset, cmd.accept |=> state_ff == ppmmu_pkg::ST_EXEC)
   // Execution is always followed by the finish step on the next cycle.
   `ASSERT_CLK(a_exec_finish, clock, reset, cmd.exec |=> state_ff == ppmmu_pkg::ST_FINISH)
   // A loaded response is presented on the following cycle.
   `ASSERT_CLK(a_load_valid, clock, reset, cmd.out_load |=> rsp_valid_ff)
   // A response appears only out of the finish step.
   `ASSERT_IMPL(a_rise_src, clock, reset, $rose(rsp_valid_ff),
                $past(state_ff == ppmmu_pkg::ST_FINISH))

endmodule

// File: rtl/ppmmu_dp.sv
// Datapath of the page table MMU: page table, byte memory and response register.
`timescale 1ns / 1ps
module ppmmu_dp #(
   parameter int NUM_PROCS      = 4,
   parameter int PAGES_PER_PROC = 4,
   parameter int PAGE_BYTES     = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ppmmu_pkg::ctrl_cmd_type  cmd,
   output ppmmu_pkg::dp_status_type stat,
   input  ppmmu_pkg::req_type       req_data,
   output ppmmu_pkg::rsp_type       rsp_data
);

   localparam int VA_W        = ppmmu_pkg::VA_W;
   localparam int VA_MAX      = (1 << VA_W) - 1;
   localparam int ENTRY_COUNT = NUM_PROCS * PAGES_PER_PROC;
   localparam int MEM_BYTES   = ENTRY_COUNT * PAGE_BYTES;
   localparam int ENTRY_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int ESUM_W      = ENTRY_W + 1;
   localparam int SLOT_W      = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
   localparam int OFF_W       = $clog2(PAGE_BYTES);
   localparam int PA_W        = $clog2(MEM_BYTES);
   localparam int PROD_W      = PA_W + 1;
   localparam int MAX_PAGE    = VA_MAX / PAGE_BYTES;
   localparam int CALC_W      = 8;
   localparam logic [VA_W-1:0] PB_VA = VA_W'(PAGE_BYTES);

   // Request decode signals.
   logic [VA_W-1:0]       page_dec;
   logic [VA_W-1:0]       off_va;
   logic [OFF_W+VA_W-1:0] off_wide;
   logic [OFF_W-1:0]      offset_dec;
   logic [CALC_W-1:0]     base_calc;
   logic [CALC_W-1:0]     idx_calc;
   logic                  in_range_dec;

   // Registered request.
   logic [1:0]         func_ff;
   logic [7:0]         value_ff;
   logic               in_range_ff;
   logic [ENTRY_W-1:0] base_ff;
   logic [ENTRY_W-1:0] idx_ff;
   logic [OFF_W-1:0]   offset_ff;

   // Page table: valid bits in flops, writable flag and frame in a memory.
   logic [ENTRY_COUNT-1:0] valid_ff;
   logic [ENTRY_W:0]       tbl_mem [ENTRY_COUNT];
   logic [ENTRY_W:0]       tbl_rdata_ff;

   // Byte memory and its clearing counter.
   logic [7:0]      mem_bytes [MEM_BYTES];
   logic [7:0]      mem_rdata_ff;
   logic [PA_W-1:0] clr_ff, clr_in;
   logic            mem_we;
   logic [PA_W-1:0] mem_waddr;
   logic [7:0]      mem_wdata;

   // Execution signals.
   logic [PAGES_PER_PROC-1:0] proc_valid;
   logic [ESUM_W-1:0]         ent_sum;
   logic [ESUM_W-1:0]         frame_sum;
   logic [SLOT_W-1:0]         slot;
   logic [ENTRY_W-1:0]        new_frame;
   logic [ENTRY_W-1:0]        cur_frame;
   logic                      cur_writable;
   logic                      ent_valid;
   logic [PROD_W-1:0]         pa_prod;
   logic [PA_W-1:0]           pa_calc;
   logic                      map_wr;
   logic                      store_wr;
   logic                      load_rd;

   // Pending result and response register.
   logic [2:0]         pend_status_ff, pend_status_in;
   logic [ENTRY_W-1:0] pend_frame_ff, pend_frame_in;
   logic [PA_W-1:0]    pend_pa_ff, pend_pa_in;
   logic [ENTRY_W+3:0] frame_wide;
   logic [PA_W+7:0]    pa_wide;
   ppmmu_pkg::rsp_type rsp_ff;

   // Split the virtual address into page and offset by comparing against page bounds.
   always_comb begin
      page_dec = '0;
      for (int k = 1; k <= MAX_PAGE; k++) begin
         if ({2'b00, req_data.virtual_address} >= CALC_W'(k * PAGE_BYTES)) begin
            page_dec = VA_W'(k);
         end
      end
      off_va     = req_data.virtual_address - page_dec * PB_VA;
      off_wide   = {{OFF_W{1'b0}}, off_va};
      offset_dec = off_wide[OFF_W-1:0];
      base_calc  = CALC_W'(req_data.process_id) * CALC_W'(PAGES_PER_PROC);
      idx_calc   = base_calc + CALC_W'(page_dec);
      in_range_dec = (req_data.func <= ppmmu_pkg::FUNC_LOAD) &&
                     ({3'b000, req_data.process_id} < 5'(NUM_PROCS)) &&
                     (page_dec < VA_W'(PAGES_PER_PROC));
   end

   // Capture the request and read its page table entry.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff      <= req_data.func;
         value_ff     <= req_data.value;
         in_range_ff  <= in_range_dec;
         base_ff      <= base_calc[ENTRY_W-1:0];
         idx_ff       <= idx_calc[ENTRY_W-1:0];
         offset_ff    <= offset_dec;
         tbl_rdata_ff <= tbl_mem[idx_calc[ENTRY_W-1:0]];
      end
   end

   // Find the first invalid entry of the process and translate the address.
   always_comb begin
      ent_sum = '0;
      for (int i = 0; i < PAGES_PER_PROC; i++) begin
         ent_sum       = {1'b0, base_ff} + ESUM_W'(i);
         proc_valid[i] = valid_ff[ent_sum[ENTRY_W-1:0]];
      end
      slot = '0;
      for (int i = PAGES_PER_PROC - 1; i >= 0; i--) begin
         if (!proc_valid[i]) slot = SLOT_W'(i);
      end
      frame_sum    = {1'b0, base_ff} + ESUM_W'(slot);
      new_frame    = frame_sum[ENTRY_W-1:0];
      cur_frame    = tbl_rdata_ff[ENTRY_W-1:0];
      cur_writable = tbl_rdata_ff[ENTRY_W];
      ent_valid    = valid_ff[idx_ff];
      pa_prod      = PROD_W'(cur_frame) * PROD_W'(PAGE_BYTES) + PROD_W'(offset_ff);
      pa_calc      = pa_prod[PA_W-1:0];
   end

   // Operation decode and result selection.
   always_comb begin
      pend_status_in = ppmmu_pkg::STATUS_INVALID;
      pend_frame_in  = '0;
      pend_pa_in     = '0;
      map_wr         = 1'b0;
      store_wr       = 1'b0;
      load_rd        = 1'b0;
      if (in_range_ff) begin
         unique case (func_ff)
            ppmmu_pkg::FUNC_MAP: begin
               if (ent_valid) begin
                  pend_status_in = ppmmu_pkg::STATUS_ALREADY;
               end else begin
                  pend_status_in = ppmmu_pkg::STATUS_MAPPED;
                  pend_frame_in  = new_frame;
                  map_wr         = cmd.exec;
               end
            end
            ppmmu_pkg::FUNC_STORE: begin
               if (ent_valid) begin
                  pend_pa_in = pa_calc;
                  if (cur_writable) begin
                     pend_status_in = ppmmu_pkg::STATUS_STORED;
                     store_wr       = cmd.exec;
                  end else begin
                     pend_status_in = ppmmu_pkg::STATUS_PROTECTED;
                  end
               end
            end
            ppmmu_pkg::FUNC_LOAD: begin
               if (ent_valid) begin
                  pend_status_in = ppmmu_pkg::STATUS_LOADED;
                  pend_pa_in     = pa_calc;
                  load_rd        = cmd.exec;
               end
            end
            default: begin
               pend_status_in = ppmmu_pkg::STATUS_INVALID;
            end
         endcase
      end
   end

   // Valid bits are cleared at reset and set by a successful map.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (map_wr) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Page table memory write on a successful map.
   always_ff @(posedge clock) begin
      if (map_wr) begin
         tbl_mem[idx_ff] <= {(value_ff != 8'd0), new_frame};
      end
   end

   // Clearing pass counter over the byte memory after reset.
   assign clr_in          = clr_ff + PA_W'(1);
   assign stat.clear_done = (clr_ff == PA_W'(MEM_BYTES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_in;
      end
   end

   // Byte memory: one write port shared by clearing and stores, one read port.
   assign mem_we    = cmd.clear_wr || store_wr;
   assign mem_waddr = cmd.clear_wr ? clr_ff : pa_calc;
   assign mem_wdata = cmd.clear_wr ? 8'd0 : value_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_bytes[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rd) begin
         mem_rdata_ff <= mem_bytes[pa_calc];
      end
   end

   // Hold the result while the byte memory read completes.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pend_status_ff <= pend_status_in;
         pend_frame_ff  <= pend_frame_in;
         pend_pa_ff     <= pend_pa_in;
      end
   end

   // Response register, masked to the response field widths.
   assign frame_wide = {4'b0000, pend_frame_ff};
   assign pa_wide    = {8'd0, pend_pa_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.status           <= pend_status_ff;
         rsp_ff.frame_number     <= frame_wide[3:0];
         rsp_ff.physical_address <= pa_wide[7:0];
         rsp_ff.read_data        <= (pend_status_ff == ppmmu_pkg::STATUS_LOADED) ?
                                    mem_rdata_ff : 8'd0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
